### rtl/urrb_pkg.sv
// ----------------------------------------------------------------------------
// urrb_pkg
// Shared types and constants for the serial receive ring buffer.
// ----------------------------------------------------------------------------
package urrb_pkg;

  localparam int DEPTH_DEF     = 2048;
  localparam int MAX_BURST_DEF = 64;

  localparam int OP_W   = 2;
  localparam int DATA_W = 8;
  localparam int CNT_W  = 7;
  localparam int WORD_W = 10;

  localparam logic [DATA_W-1:0] MASK_RESET = 8'h1e;
  localparam logic [WORD_W-1:0] ERR_BIT    = 10'h200;
  localparam logic [WORD_W-1:0] ZERO_CODE  = 10'h100;

  typedef enum logic [OP_W-1:0] {
    OP_RECEIVE = 2'd0,
    OP_GET     = 2'd1,
    OP_BURST   = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  // command passed from the front queue to the back engine
  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] rx_data;
    logic              err;
    logic [CNT_W-1:0]  count;
  } cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0] data_word;
    logic              empty_res;
    logic              last;
  } result_t;

endpackage

### rtl/urrb_if.sv
// ----------------------------------------------------------------------------
// urrb channel interfaces
// Valid/ready channels for command transactions and result transactions.
// ----------------------------------------------------------------------------
interface urrb_in_if;
  logic                        valid;
  logic                        ready;
  logic [urrb_pkg::OP_W-1:0]   operation;
  logic [urrb_pkg::DATA_W-1:0] rx_data;
  logic [urrb_pkg::DATA_W-1:0] line_status;
  logic [urrb_pkg::CNT_W-1:0]  max_count;

  modport source (output valid, operation, rx_data, line_status, max_count, input ready);
  modport sink (input valid, operation, rx_data, line_status, max_count, output ready);
endinterface

interface urrb_out_if;
  logic                        valid;
  logic                        ready;
  logic [urrb_pkg::WORD_W-1:0] data_word;
  logic                        empty_res;
  logic                        last;

  modport source (output valid, data_word, empty_res, last, input ready);
  modport sink (input valid, data_word, empty_res, last, output ready);
endinterface

### rtl/urrb_front.sv
// ----------------------------------------------------------------------------
// urrb_front
// Accepts command transactions, classifies them and holds them in a
// two-entry queue in front of the back engine. Also holds the error mask.
// ----------------------------------------------------------------------------
module urrb_front #(
  parameter int MAX_BURST = urrb_pkg::MAX_BURST_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [urrb_pkg::DATA_W-1:0] cfg_wr_data,
  urrb_in_if.sink                     in_ch,
  output logic                        cmd_valid,
  output urrb_pkg::cmd_t              cmd,
  input  logic                        cmd_ready
);

  localparam logic [urrb_pkg::CNT_W-1:0] BURST_MAX = urrb_pkg::CNT_W'(MAX_BURST);

  logic [urrb_pkg::DATA_W-1:0] error_mask;
  urrb_pkg::cmd_t              queue [2];
  logic                        wr_sel;
  logic                        rd_sel;
  logic [1:0]                  count;
  urrb_pkg::cmd_t              cmd_in;
  logic                        accept;
  logic                        push;
  logic                        pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      error_mask <= urrb_pkg::MASK_RESET;
    end else if (cfg_wr_en) begin
      error_mask <= cfg_wr_data;
    end
  end

  always_comb begin
    cmd_in.op      = urrb_pkg::op_t'(in_ch.operation);
    cmd_in.rx_data = in_ch.rx_data;
    cmd_in.err     = |(in_ch.line_status & error_mask);
    if (in_ch.max_count == '0) begin
      cmd_in.count = urrb_pkg::CNT_W'(1);
    end else if (in_ch.max_count > BURST_MAX) begin
      cmd_in.count = BURST_MAX;
    end else begin
      cmd_in.count = in_ch.max_count;
    end
  end

  assign in_ch.ready = (count != 2'd2);
  assign accept      = in_ch.valid && in_ch.ready;
  // unknown operation gives no result and touches no state
  assign push        = accept && (cmd_in.op != urrb_pkg::OP_NONE);
  assign cmd_valid   = (count != 2'd0);
  assign cmd         = queue[rd_sel];
  assign pop         = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_sel] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_sel <= 1'b0;
      rd_sel <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_sel <= ~wr_sel;
      end
      if (pop) begin
        rd_sel <= ~rd_sel;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### rtl/urrb_back.sv
// ----------------------------------------------------------------------------
// urrb_back
// Executes queued commands: ring memory, pointers, error flag, burst
// sequencer, read stage and a two-entry result queue.
// ----------------------------------------------------------------------------
module urrb_back #(
  parameter int DEPTH = urrb_pkg::DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  urrb_pkg::cmd_t cmd,
  output logic           cmd_ready,
  urrb_out_if.source     out_ch
);

  localparam int            AW       = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_BURST = 2'b10
  } state_t;

  // ring memory
  logic [urrb_pkg::DATA_W-1:0] mem [DEPTH];
  logic [urrb_pkg::DATA_W-1:0] rd_data;

  state_t                     state;
  state_t                     state_next;
  logic [AW-1:0]              wr_ptr;
  logic [AW-1:0]              wr_ptr_next;
  logic [AW-1:0]              rd_ptr;
  logic [AW-1:0]              rd_ptr_next;
  logic                       error_pending;
  logic                       error_pending_next;
  logic [urrb_pkg::CNT_W-1:0] remain;
  logic [urrb_pkg::CNT_W-1:0] remain_next;
  logic [AW-1:0]              wr_inc;
  logic [AW-1:0]              rd_inc;
  logic                       buf_empty;
  logic                       mem_we;

  // read stage
  logic stg_valid;
  logic stg_from_mem;
  logic stg_get;
  logic stg_err;
  logic stg_empty;
  logic stg_last;
  logic issue;
  logic iss_from_mem;
  logic iss_get;
  logic iss_err;
  logic iss_empty;
  logic iss_last;

  // result queue
  urrb_pkg::result_t ofifo [2];
  urrb_pkg::result_t stg_res;
  logic              owr_sel;
  logic              ord_sel;
  logic [1:0]        ocnt;
  logic              opop;
  logic [2:0]        occ;
  logic              can_issue;
  logic              cmd_take;
  logic [urrb_pkg::WORD_W-1:0] get_word;

  assign buf_empty = (rd_ptr == wr_ptr);
  assign wr_inc    = (wr_ptr == LAST_IDX) ? '0 : wr_ptr + AW'(1);
  assign rd_inc    = (rd_ptr == LAST_IDX) ? '0 : rd_ptr + AW'(1);

  assign opop      = out_ch.valid && out_ch.ready;
  assign occ       = {1'b0, ocnt} + {2'b0, stg_valid} - {2'b0, opop};
  assign can_issue = (occ < 3'd2);

  always_comb begin
    cmd_ready = 1'b0;
    if (state == ST_IDLE) begin
      cmd_ready = (cmd.op == urrb_pkg::OP_RECEIVE) || can_issue;
    end
  end

  assign cmd_take = cmd_valid && cmd_ready;

  always_comb begin
    state_next         = state;
    wr_ptr_next        = wr_ptr;
    rd_ptr_next        = rd_ptr;
    error_pending_next = error_pending;
    remain_next        = remain;
    mem_we             = 1'b0;
    issue              = 1'b0;
    iss_from_mem       = 1'b0;
    iss_get            = 1'b0;
    iss_err            = 1'b0;
    iss_empty          = 1'b0;
    iss_last           = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (cmd_take) begin
          unique case (cmd.op)
            urrb_pkg::OP_RECEIVE: begin
              mem_we             = 1'b1;
              wr_ptr_next        = wr_inc;
              error_pending_next = cmd.err;
            end
            urrb_pkg::OP_GET: begin
              issue    = 1'b1;
              iss_last = 1'b1;
              if (!buf_empty) begin
                iss_from_mem       = 1'b1;
                iss_get            = 1'b1;
                iss_err            = error_pending;
                rd_ptr_next        = rd_inc;
                error_pending_next = 1'b0;
              end
            end
            urrb_pkg::OP_BURST: begin
              issue = 1'b1;
              if (buf_empty) begin
                iss_empty = 1'b1;
                iss_last  = 1'b1;
              end else begin
                iss_from_mem       = 1'b1;
                iss_last           = (cmd.count == urrb_pkg::CNT_W'(1)) || (rd_inc == wr_ptr);
                rd_ptr_next        = rd_inc;
                error_pending_next = 1'b0;
                remain_next        = cmd.count - urrb_pkg::CNT_W'(1);
                if (!iss_last) begin
                  state_next = ST_BURST;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_BURST: begin
        if (can_issue) begin
          issue              = 1'b1;
          iss_from_mem       = 1'b1;
          iss_last           = (remain == urrb_pkg::CNT_W'(1)) || (rd_inc == wr_ptr);
          rd_ptr_next        = rd_inc;
          error_pending_next = 1'b0;
          remain_next        = remain - urrb_pkg::CNT_W'(1);
          if (iss_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_ptr] <= cmd.rx_data;
    end
    if (issue && iss_from_mem) begin
      rd_data <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      error_pending <= 1'b0;
      remain        <= '0;
      stg_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      wr_ptr        <= wr_ptr_next;
      rd_ptr        <= rd_ptr_next;
      error_pending <= error_pending_next;
      remain        <= remain_next;
      stg_valid     <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      stg_from_mem <= iss_from_mem;
      stg_get      <= iss_get;
      stg_err      <= iss_err;
      stg_empty    <= iss_empty;
      stg_last     <= iss_last;
    end
  end

  // error bit goes in before the zero test
  always_comb begin
    get_word = {stg_err, 1'b0, rd_data};
    if (get_word == '0) begin
      get_word = urrb_pkg::ZERO_CODE;
    end
  end

  always_comb begin
    stg_res.empty_res = stg_empty;
    stg_res.last      = stg_last;
    if (!stg_from_mem) begin
      stg_res.data_word = '0;
    end else if (stg_get) begin
      stg_res.data_word = get_word;
    end else begin
      stg_res.data_word = {2'b00, rd_data};
    end
  end

  always_ff @(posedge clk) begin
    if (stg_valid) begin
      ofifo[owr_sel] <= stg_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owr_sel <= 1'b0;
      ord_sel <= 1'b0;
      ocnt    <= 2'd0;
    end else begin
      if (stg_valid) begin
        owr_sel <= ~owr_sel;
      end
      if (opop) begin
        ord_sel <= ~ord_sel;
      end
      ocnt <= ocnt + {1'b0, stg_valid} - {1'b0, opop};
    end
  end

  assign out_ch.valid     = (ocnt != 2'd0);
  assign out_ch.data_word = ofifo[ord_sel].data_word;
  assign out_ch.empty_res = ofifo[ord_sel].empty_res;
  assign out_ch.last      = ofifo[ord_sel].last;

endmodule

### rtl/uart_receive_ring_buffer.sv
// ----------------------------------------------------------------------------
// uart_receive_ring_buffer
// Receive ring buffer for one serial port: stores line bytes, answers single
// gets and bursts of up to MAX_BURST bytes.
//
//   channel   dir   handshake      carries
//   in_ch     in    valid/ready    operation, rx_data, line_status, max_count
//   out_ch    out   valid/ready    data_word, empty_res, last
//   cfg       in    cfg_wr_en      cfg_wr_data -> error_mask
//
// a burst issues one ring memory read per cycle while the result queue has room
// first result becomes valid on out_ch after the command queue, the memory read
// register and the result queue
// a two-entry command queue keeps in_ch ready while results wait on out_ch, until it is full
// rst is synchronous; pointers and error flag clear, memory contents do not
// ----------------------------------------------------------------------------
module uart_receive_ring_buffer #(
  parameter int DEPTH     = urrb_pkg::DEPTH_DEF,
  parameter int MAX_BURST = urrb_pkg::MAX_BURST_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [urrb_pkg::DATA_W-1:0] cfg_wr_data,
  urrb_in_if.sink                     in_ch,
  urrb_out_if.source                  out_ch
);

  logic           cmd_valid;
  logic           cmd_ready;
  urrb_pkg::cmd_t cmd;

  urrb_front #(
    .MAX_BURST (MAX_BURST)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_ready   (cmd_ready)
  );

  urrb_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .out_ch    (out_ch)
  );

endmodule

### rtl/urrb_checker.sv
// ----------------------------------------------------------------------------
// urrb_checker
// Port-level checks on the result channel of the receive ring buffer.
// ----------------------------------------------------------------------------
module urrb_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [urrb_pkg::WORD_W-1:0] out_data_word,
  input logic                        out_empty_res,
  input logic                        out_last
);

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      $stable(out_data_word) && $stable(out_empty_res) && $stable(out_last))
    else $error("result payload changed while stalled");

  a_empty_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_empty_res |-> out_last && (out_data_word == '0))
    else $error("empty burst transaction not a single zero last word");

  a_zero_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data_word[8] |-> (out_data_word[7:0] == '0) && !out_empty_res)
    else $error("zero byte code carries byte bits");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind uart_receive_ring_buffer urrb_checker u_urrb_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_data_word (out_ch.data_word),
  .out_empty_res (out_ch.empty_res),
  .out_last      (out_ch.last)
);

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uart_receive_ring_buffer testbench
// Drives receive, get, burst and no-op transactions into the ring buffer with random
// gaps on both channels. A behavioral copy of the ring, its pointers and the
// error flag predicts every result word, which is checked in order as it
// leaves the block. Covers empty reads, zero-byte and error encoding, burst
// count clamping, mask changes and long output stalls.
// ----------------------------------------------------------------------------
module testbench;
  import urrb_pkg::*;

  localparam int PTR_W       = $clog2(DEPTH_DEF);
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 10;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_wr_en;
  logic [DATA_W-1:0] cfg_wr_data;

  urrb_in_if  in_ch ();
  urrb_out_if out_ch ();

  uart_receive_ring_buffer dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  always #5 clk = ~clk;

  // ring model
  logic [DATA_W-1:0] ring_mem [DEPTH_DEF];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic              err_pend;
  logic [DATA_W-1:0] err_mask;
  result_t           words_due [$];

  int      fails = 0;
  int      idle_cycles = 0;
  bit      quiet = 1'b0;
  bit      hold_req = 1'b0;
  result_t word_want;

  task automatic predict_ring_words(input op_t op, input logic [DATA_W-1:0] rx,
                                    input logic [DATA_W-1:0] ls,
                                    input logic [CNT_W-1:0] cnt);
    result_t r;
    int      n_max;
    int      n;
    case (op)
      OP_RECEIVE: begin
        ring_mem[wr_ptr] = rx;
        wr_ptr = wr_ptr + 1'b1;
        err_pend = |(ls & err_mask);
      end
      OP_GET: begin
        r = '0;
        r.last = 1'b1;
        if (rd_ptr != wr_ptr) begin
          r.data_word = {2'b00, ring_mem[rd_ptr]};
          rd_ptr = rd_ptr + 1'b1;
          if (err_pend) begin
            r.data_word = r.data_word | ERR_BIT;
            err_pend = 1'b0;
          end
          if (r.data_word == '0) r.data_word = ZERO_CODE;
        end
        words_due.push_back(r);
      end
      OP_BURST: begin
        n_max = (cnt == 0) ? 1 : ((cnt > MAX_BURST_DEF) ? MAX_BURST_DEF : int'(cnt));
        if (rd_ptr == wr_ptr) begin
          r = '0;
          r.empty_res = 1'b1;
          r.last = 1'b1;
          words_due.push_back(r);
        end else begin
          n = 0;
          while (rd_ptr != wr_ptr && n < n_max) begin
            r = '0;
            r.data_word = {2'b00, ring_mem[rd_ptr]};
            rd_ptr = rd_ptr + 1'b1;
            err_pend = 1'b0;
            n++;
            r.last = (rd_ptr == wr_ptr) || (n == n_max);
            words_due.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      wr_ptr = '0;
      rd_ptr = '0;
      err_pend = 1'b0;
      err_mask = MASK_RESET;
    end else begin
      if (cfg_wr_en) err_mask = cfg_wr_data;
      if (in_ch.valid && in_ch.ready)
        predict_ring_words(op_t'(in_ch.operation), in_ch.rx_data, in_ch.line_status,
                           in_ch.max_count);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (words_due.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual word %h empty %b last %b",
                 $time, out_ch.data_word, out_ch.empty_res, out_ch.last);
        fails++;
      end else begin
        word_want = words_due.pop_front();
        if (out_ch.data_word !== word_want.data_word) begin
          $display("%0t: data_word expected %h actual %h", $time, word_want.data_word,
                   out_ch.data_word);
          fails++;
        end
        if (out_ch.empty_res !== word_want.empty_res) begin
          $display("%0t: empty_res expected %b actual %b", $time, word_want.empty_res,
                   out_ch.empty_res);
          fails++;
        end
        if (out_ch.last !== word_want.last) begin
          $display("%0t: last expected %b actual %b", $time, word_want.last, out_ch.last);
          fails++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("uart_receive_ring_buffer test failed");
      $finish;
    end
  end

  // result receiver
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        gap = quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        do @(posedge clk); while (!out_ch.valid && !hold_req);
      end
    end
  end

  function automatic logic [DATA_W-1:0] rand_byte();
    return ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom);
  endfunction

  task automatic send_op(input op_t op, input logic [DATA_W-1:0] rx,
                         input logic [DATA_W-1:0] ls, input logic [CNT_W-1:0] cnt);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.rx_data     <= rx;
    in_ch.line_status <= ls;
    in_ch.max_count   <= cnt;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic put_byte(input logic [DATA_W-1:0] rx, input logic [DATA_W-1:0] ls);
    send_op(OP_RECEIVE, rx, ls, CNT_W'($urandom));
  endtask

  task automatic get_entry();
    send_op(OP_GET, 8'($urandom), 8'($urandom), CNT_W'($urandom));
  endtask

  task automatic burst_read(input logic [CNT_W-1:0] cnt);
    send_op(OP_BURST, 8'($urandom), 8'($urandom), cnt);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_error_mask(input logic [DATA_W-1:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic test_basic_ops();
    get_entry();
    burst_read(7'd5);
    send_op(OP_NONE, 8'hff, 8'hff, 7'h7f);
    put_byte(8'h00, 8'h00);
    put_byte(8'hff, 8'h00);
    put_byte(8'h80, 8'h01);
    get_entry();
    get_entry();
    get_entry();
    // zero byte with error pending
    put_byte(8'h00, 8'h02);
    get_entry();
    // later receive replaces the error flag
    put_byte(8'h55, 8'h10);
    put_byte(8'haa, 8'he0);
    get_entry();
    get_entry();
    // burst clears the error flag
    put_byte(8'h12, 8'h00);
    put_byte(8'h34, 8'h08);
    burst_read(7'd1);
    get_entry();
    // count clamping
    put_byte(8'h01, 8'h00);
    put_byte(8'h02, 8'h00);
    put_byte(8'h03, 8'h00);
    burst_read(7'd0);
    burst_read(7'h7f);
    drain_results();
  endtask

  task automatic test_error_mask();
    set_error_mask(8'h00);
    put_byte(8'h5a, 8'hff);
    get_entry();
    set_error_mask(8'hff);
    put_byte(8'h00, 8'h80);
    get_entry();
    set_error_mask(8'h01);
    put_byte(8'h11, 8'h01);
    get_entry();
    put_byte(8'h22, 8'h02);
    get_entry();
    set_error_mask(8'($urandom));
    repeat (6) put_byte(rand_byte(), 8'($urandom));
    burst_read(7'd3);
    repeat (3) get_entry();
    set_error_mask(MASK_RESET);
  endtask

  task automatic test_backpressure();
    quiet = 1'b1;
    hold_req = 1'b1;
    repeat (40) put_byte(rand_byte(), 8'($urandom));
    burst_read(7'd64);
    repeat (10) put_byte(rand_byte(), 8'($urandom));
    burst_read(7'd5);
    repeat (4) get_entry();
    burst_read(7'd64);
    quiet = 1'b0;
    drain_results();
  endtask

  task automatic test_random_traffic();
    logic [DATA_W-1:0] masks [4];
    logic [CNT_W-1:0]  cnt;
    int                pick;
    masks = '{8'h00, 8'hff, 8'($urandom), 8'($urandom)};
    for (int ph = 0; ph < 4; ph++) begin
      set_error_mask(masks[ph]);
      for (int i = 0; i < 15; i++) begin
        if (i % 8 == 0) quiet = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          put_byte(rand_byte(), 8'($urandom));
        end else if (pick < 72) begin
          get_entry();
        end else if (pick < 95) begin
          pick = $urandom_range(0, 99);
          if (pick < 70) cnt = CNT_W'($urandom_range(1, 8));
          else if (pick < 80) cnt = '0;
          else if (pick < 90) cnt = CNT_W'(MAX_BURST_DEF);
          else cnt = CNT_W'($urandom_range(9, 127));
          burst_read(cnt);
        end else begin
          send_op(OP_NONE, 8'($urandom), 8'($urandom), CNT_W'($urandom));
        end
      end
    end
    quiet = 1'b0;
    drain_results();
  endtask

  initial begin
    rst               <= 1'b1;
    cfg_wr_en         <= 1'b0;
    cfg_wr_data       <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.operation   <= OP_NONE;
    in_ch.rx_data     <= '0;
    in_ch.line_status <= '0;
    in_ch.max_count   <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_ops();
    test_error_mask();
    test_backpressure();
    test_random_traffic();
    if (fails == 0 && words_due.size() == 0) begin
      $display("uart_receive_ring_buffer test passed");
    end else begin
      $display("uart_receive_ring_buffer test failed");
    end
    $finish;
  end

endmodule
